// ----- hw/rtl/triangle_metrics_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for triangle_metrics_unit
// Implication checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_METRICS_UNIT_ASSERT_SVH
`define TRIANGLE_METRICS_UNIT_ASSERT_SVH

// same-cycle implication
`define TMU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TMU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tmu_pkg.sv -----
// ----------------------------------------------------------------------------
// tmu_pkg
// Beat types, widths and codes of the triangle metrics unit.
// ----------------------------------------------------------------------------
package tmu_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned LEN_W     = 24;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned PER_W     = 26;
  localparam int unsigned AREA_W    = 40;
  localparam int unsigned TOL_W     = 16;

  localparam int unsigned DIFF_W  = COORD_W + 1;        // |coordinate difference|
  localparam int unsigned SQ_W    = 2 * LEN_W;          // length squared
  localparam int unsigned VSQ_W   = 2 * DIFF_W;         // difference squared
  localparam int unsigned MRAD_W  = SQ_W + 2;           // 2y^2 + 2z^2 - x^2
  localparam int unsigned RAD1_W  = MRAD_W + 2;         // 4 * median radicand
  localparam int unsigned ROOT1_W = RAD1_W / 2;
  localparam int unsigned FAC_W   = PER_W;              // Heron factor
  localparam int unsigned PROD_W  = 2 * FAC_W;
  localparam int unsigned HERON_SH = 2 * FRAC_BITS + 4;
  localparam int unsigned RAD2_W  = 2 * PROD_W - HERON_SH;
  localparam int unsigned ROOT2_W = RAD2_W / 2;

  // exact floor(x / 3) for x below 2^27
  localparam int unsigned DIV3_SH = 28;
  localparam logic [DIV3_SH-1:0] DIV3_MUL = 28'h5555556;

  localparam logic [1:0] ACT_SIDES    = 2'd0;
  localparam logic [1:0] ACT_MEDIANS  = 2'd1;
  localparam logic [1:0] ACT_VERTICES = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic [LEN_W-1:0]         len_a;
    logic [LEN_W-1:0]         len_b;
    logic [LEN_W-1:0]         len_c;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic signed [COORD_W-1:0] x3;
    logic signed [COORD_W-1:0] y3;
  } tmu_in_t;

  typedef struct packed {
    logic              valid_res;
    logic [LEN_W-1:0]  side_a;
    logic [LEN_W-1:0]  side_b;
    logic [LEN_W-1:0]  side_c;
    logic [PER_W-1:0]  perimeter;
    logic [AREA_W-1:0] area;
    logic [LEN_W-1:0]  median_a;
    logic [LEN_W-1:0]  median_b;
    logic [LEN_W-1:0]  median_c;
    logic              is_right;
    logic [LEN_W-1:0]  inradius;
    logic [LEN_W-1:0]  circumradius;
  } tmu_out_t;

endpackage

// ----- hw/rtl/tmu_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// tmu_sqrt_pipe
// Pipelined integer square root, one root bit per stage, several lanes
// sharing one valid and one sideband.
// ----------------------------------------------------------------------------
module tmu_sqrt_pipe #(
  parameter int unsigned LANES  = 1,
  parameter int unsigned RAD_W  = 8,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [LANES-1:0][RAD_W-1:0]       rad_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic [LANES-1:0][RAD_W/2-1:0]     root_o,
  output logic [SIDE_W-1:0]                 side_o
);
  localparam int unsigned ROOT_W = RAD_W / 2;

  logic [ROOT_W:0]                   vld_q;
  logic [LANES-1:0][RAD_W-1:0]       rem_q  [ROOT_W+1];
  logic [LANES-1:0][ROOT_W-1:0]      root_q [ROOT_W+1];
  logic [SIDE_W-1:0]                 side_q [ROOT_W+1];

  // (2q + 2^b) * 2^b with q holding only bits above b
  function automatic logic [RAD_W-1:0] trial_f(input logic [ROOT_W-1:0] q, input int b);
    trial_f = (RAD_W'(q) << (b + 1)) | (RAD_W'(1) << (2 * b));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ROOT_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rad_i;
      root_q[0] <= '0;
      side_q[0] <= side_i;
      for (int s = 0; s < ROOT_W; s++) begin
        side_q[s+1] <= side_q[s];
        for (int l = 0; l < LANES; l++) begin
          if (rem_q[s][l] >= trial_f(root_q[s][l], ROOT_W - 1 - s)) begin
            rem_q[s+1][l]  <= rem_q[s][l] - trial_f(root_q[s][l], ROOT_W - 1 - s);
            root_q[s+1][l] <= root_q[s][l] | (ROOT_W'(1) << (ROOT_W - 1 - s));
          end else begin
            rem_q[s+1][l]  <= rem_q[s][l];
            root_q[s+1][l] <= root_q[s][l];
          end
        end
      end
    end
  end

  assign valid_o = vld_q[ROOT_W];
  assign root_o  = root_q[ROOT_W];
  assign side_o  = side_q[ROOT_W];

endmodule

// ----- hw/rtl/triangle_metrics_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_metrics_unit
// Fixed-point triangle metrics: sides, perimeter, Heron area, medians and a
// right-triangle test, from sides, medians or vertex coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one triangle per
//   beat; output channel out_valid_o / out_stall_i / out_data_o returns one
//   result beat per input beat, in order.
//   cfg_we_i / cfg_wdata_i write right_tolerance (reset 0); write only while
//   the pipeline is empty.
//   Depth: 80 register stages, which an accepted beat passes in order up to
//   the output register. Most of them are in two bit-per-stage square-root
//   pipelines: 26 root stages for median/vertex side lengths and 42 root
//   stages for the Heron area radicand.
//   Throughput: one beat per cycle while the receiver does not stall.
//   When out_stall_i holds a valid result, the whole pipeline freezes and
//   in_stall_o rises in the same cycle; nothing is dropped or duplicated.
//   Reset clears all valid bits and the tolerance register.
// ----------------------------------------------------------------------------
`include "triangle_metrics_unit_assert.svh"

module triangle_metrics_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  tmu_pkg::tmu_in_t        in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output tmu_pkg::tmu_out_t       out_data_o,
  input  logic                    cfg_we_i,
  input  logic [tmu_pkg::TOL_W-1:0] cfg_wdata_i
);
  import tmu_pkg::*;

  typedef logic [LEN_W-1:0] len_t;

  // sideband through the side-length root
  typedef struct packed {
    logic [1:0] act;
    len_t       la;
    len_t       lb;
    len_t       lc;
    logic       mok;
  } s1_t;

  // sideband through the area / median root
  typedef struct packed {
    logic             tri_ok;
    len_t             a;
    len_t             b;
    len_t             c;
    logic [PER_W-1:0] per;
    logic             right;
    len_t             inr;
    len_t             circ;
  } s2_t;

  localparam int unsigned S1_W = $bits(s1_t);
  localparam int unsigned S2_W = $bits(s2_t);

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic [DIFF_W-1:0] absdiff_f(input logic [COORD_W-1:0] p,
                                                  input logic [COORD_W-1:0] q);
    logic signed [DIFF_W-1:0] d;
    d = signed'({q[COORD_W-1], q}) - signed'({p[COORD_W-1], p});
    absdiff_f = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  // 2y^2 + 2z^2 - x^2, clamped at zero
  function automatic logic [MRAD_W-1:0] medrad_f(input logic [SQ_W-1:0] xs,
                                                 input logic [SQ_W-1:0] ys,
                                                 input logic [SQ_W-1:0] zs);
    logic [MRAD_W-1:0] s;
    logic [MRAD_W-1:0] q;
    s = MRAD_W'({ys, 1'b0}) + MRAD_W'({zs, 1'b0});
    q = MRAD_W'(xs);
    medrad_f = (s > q) ? s - q : '0;
  endfunction

  function automatic len_t sat_len_f(input logic [ROOT1_W-1:0] v);
    sat_len_f = (|v[ROOT1_W-1:LEN_W]) ? '1 : v[LEN_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // flow control: one enable for every stage
  // --------------------------------------------------------------------------
  logic en;
  logic vo_q;
  assign en         = !(vo_q && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vo_q;

  logic [TOL_W-1:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  logic v1_q, v2_q, v3_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic v4, v11;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      vo_q  <= 1'b0;
    end else if (en) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v5_q  <= v4;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      vo_q  <= v11;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: input register
  // --------------------------------------------------------------------------
  tmu_in_t in1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      in1_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: median squares and inequality, vertex differences
  // --------------------------------------------------------------------------
  logic [1:0]        act2_q;
  len_t              len2_q  [3];
  logic              mok2_q;
  logic [SQ_W-1:0]   msq2_q  [3];
  logic [DIFF_W-1:0] dv2_q   [6];
  len_t              len1    [3];

  assign len1[0] = in1_q.len_a;
  assign len1[1] = in1_q.len_b;
  assign len1[2] = in1_q.len_c;

  always_ff @(posedge clk_i) begin
    if (en) begin
      act2_q <= in1_q.action;
      for (int k = 0; k < 3; k++) begin
        len2_q[k] <= len1[k];
        msq2_q[k] <= SQ_W'(len1[k]) * SQ_W'(len1[k]);
      end
      mok2_q <= ((LEN_W + 1)'(len1[0]) + (LEN_W + 1)'(len1[1]) > (LEN_W + 1)'(len1[2])) &&
                ((LEN_W + 1)'(len1[0]) + (LEN_W + 1)'(len1[2]) > (LEN_W + 1)'(len1[1])) &&
                ((LEN_W + 1)'(len1[1]) + (LEN_W + 1)'(len1[2]) > (LEN_W + 1)'(len1[0]));
      // side a = |V2V3|, b = |V1V3|, c = |V1V2|
      dv2_q[0] <= absdiff_f(in1_q.x2, in1_q.x3);
      dv2_q[1] <= absdiff_f(in1_q.y2, in1_q.y3);
      dv2_q[2] <= absdiff_f(in1_q.x1, in1_q.x3);
      dv2_q[3] <= absdiff_f(in1_q.y1, in1_q.y3);
      dv2_q[4] <= absdiff_f(in1_q.x1, in1_q.x2);
      dv2_q[5] <= absdiff_f(in1_q.y1, in1_q.y2);
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: vertex squares, median radicands (times 4)
  // --------------------------------------------------------------------------
  logic [1:0]         act3_q;
  len_t               len3_q  [3];
  logic               mok3_q;
  logic [VSQ_W-1:0]   vsq3_q  [6];
  logic [RAD1_W-1:0]  mrad3_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      act3_q <= act2_q;
      mok3_q <= mok2_q;
      for (int k = 0; k < 3; k++) begin
        len3_q[k] <= len2_q[k];
      end
      for (int k = 0; k < 6; k++) begin
        vsq3_q[k] <= VSQ_W'(dv2_q[k]) * VSQ_W'(dv2_q[k]);
      end
      mrad3_q[0] <= {medrad_f(msq2_q[0], msq2_q[1], msq2_q[2]), 2'b00};
      mrad3_q[1] <= {medrad_f(msq2_q[1], msq2_q[0], msq2_q[2]), 2'b00};
      mrad3_q[2] <= {medrad_f(msq2_q[2], msq2_q[0], msq2_q[1]), 2'b00};
    end
  end

  // --------------------------------------------------------------------------
  // side-length root: sqrt(4r) for medians, sqrt(dx^2 + dy^2) for vertices
  // --------------------------------------------------------------------------
  logic [2:0][RAD1_W-1:0]  rad1;
  logic [2:0][ROOT1_W-1:0] root4;
  logic [S1_W-1:0]         side4;
  s1_t                     s3, s4;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (act3_q)
        ACT_MEDIANS:  rad1[k] = mrad3_q[k];
        ACT_VERTICES: rad1[k] = RAD1_W'(vsq3_q[2*k]) + RAD1_W'(vsq3_q[2*k+1]);
        default:      rad1[k] = '0;
      endcase
    end
  end

  assign s3.act = act3_q;
  assign s3.la  = len3_q[0];
  assign s3.lb  = len3_q[1];
  assign s3.lc  = len3_q[2];
  assign s3.mok = mok3_q;

  tmu_sqrt_pipe #(
    .LANES  (3),
    .RAD_W  (RAD1_W),
    .SIDE_W (S1_W)
  ) u_side_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (rad1),
    .side_i  (s3),
    .valid_o (v4),
    .root_o  (root4),
    .side_o  (side4)
  );

  assign s4 = s1_t'(side4);

  // --------------------------------------------------------------------------
  // stage 5: divide by three (2/3 * sqrt(r) = sqrt(4r) / 3)
  // --------------------------------------------------------------------------
  localparam int unsigned P3_W = ROOT1_W + DIV3_SH;

  s1_t                s5_q;
  logic [ROOT1_W-1:0] root5_q [3];
  logic [P3_W-1:0]    prod5_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q <= s4;
      for (int k = 0; k < 3; k++) begin
        root5_q[k] <= root4[k];
        prod5_q[k] <= P3_W'(root4[k]) * P3_W'(DIV3_MUL);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: pick and saturate sides
  // --------------------------------------------------------------------------
  len_t side6_q [3];
  logic ok6_q;
  len_t len5    [3];

  assign len5[0] = s5_q.la;
  assign len5[1] = s5_q.lb;
  assign len5[2] = s5_q.lc;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        unique case (s5_q.act)
          ACT_SIDES:    side6_q[k] <= len5[k];
          ACT_MEDIANS:  side6_q[k] <= sat_len_f(prod5_q[k][DIV3_SH +: ROOT1_W]);
          ACT_VERTICES: side6_q[k] <= sat_len_f(root5_q[k]);
          default:      side6_q[k] <= '0;
        endcase
      end
      ok6_q <= (s5_q.act == ACT_SIDES) || (s5_q.act == ACT_VERTICES) ||
               ((s5_q.act == ACT_MEDIANS) && s5_q.mok);
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: triangle check, perimeter, Heron factors, squares, radii
  // --------------------------------------------------------------------------
  logic [PER_W-1:0] per6;
  logic [PER_W-1:0] inr6;
  len_t             mx6;

  assign per6 = PER_W'(side6_q[0]) + PER_W'(side6_q[1]) + PER_W'(side6_q[2]);
  assign mx6  = (side6_q[0] >= side6_q[1]) ?
                ((side6_q[0] >= side6_q[2]) ? side6_q[0] : side6_q[2]) :
                ((side6_q[1] >= side6_q[2]) ? side6_q[1] : side6_q[2]);
  assign inr6 = per6 - PER_W'({mx6, 1'b0});

  logic             tri7_q;
  len_t             side7_q [3];
  logic [SQ_W-1:0]  sq7_q   [3];
  logic [FAC_W-1:0] fac7_q  [4];
  len_t             mx7_q, inr7_q, circ7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tri7_q <= ok6_q &&
        ((LEN_W + 1)'(side6_q[0]) + (LEN_W + 1)'(side6_q[1]) > (LEN_W + 1)'(side6_q[2])) &&
        ((LEN_W + 1)'(side6_q[0]) + (LEN_W + 1)'(side6_q[2]) > (LEN_W + 1)'(side6_q[1])) &&
        ((LEN_W + 1)'(side6_q[1]) + (LEN_W + 1)'(side6_q[2]) > (LEN_W + 1)'(side6_q[0]));
      for (int k = 0; k < 3; k++) begin
        side7_q[k] <= side6_q[k];
        sq7_q[k]   <= SQ_W'(side6_q[k]) * SQ_W'(side6_q[k]);
      end
      fac7_q[0] <= per6;
      fac7_q[1] <= FAC_W'(side6_q[1]) + FAC_W'(side6_q[2]) - FAC_W'(side6_q[0]);
      fac7_q[2] <= FAC_W'(side6_q[0]) + FAC_W'(side6_q[2]) - FAC_W'(side6_q[1]);
      fac7_q[3] <= FAC_W'(side6_q[0]) + FAC_W'(side6_q[1]) - FAC_W'(side6_q[2]);
      mx7_q     <= mx6;
      inr7_q    <= inr6[LEN_W:1];
      circ7_q   <= mx6 >> 1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: factor pairs, median radicands, sum of squares
  // --------------------------------------------------------------------------
  localparam int unsigned SUMSQ_W = SQ_W + 2;

  s2_t                 s8_q;
  logic [PROD_W-1:0]   p12_8_q, p34_8_q;
  logic [MRAD_W-1:0]   mrad8_q [3];
  logic [SUMSQ_W-1:0]  sumsq8_q;
  logic [SQ_W-1:0]     mxsq8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q.tri_ok <= tri7_q;
      s8_q.a      <= side7_q[0];
      s8_q.b      <= side7_q[1];
      s8_q.c      <= side7_q[2];
      s8_q.per    <= fac7_q[0];
      s8_q.right  <= 1'b0;
      s8_q.inr    <= inr7_q;
      s8_q.circ   <= circ7_q;
      p12_8_q    <= PROD_W'(fac7_q[0]) * PROD_W'(fac7_q[1]);
      p34_8_q    <= PROD_W'(fac7_q[2]) * PROD_W'(fac7_q[3]);
      mrad8_q[0] <= medrad_f(sq7_q[0], sq7_q[1], sq7_q[2]);
      mrad8_q[1] <= medrad_f(sq7_q[1], sq7_q[0], sq7_q[2]);
      mrad8_q[2] <= medrad_f(sq7_q[2], sq7_q[0], sq7_q[1]);
      sumsq8_q   <= SUMSQ_W'(sq7_q[0]) + SUMSQ_W'(sq7_q[1]) + SUMSQ_W'(sq7_q[2]);
      mxsq8_q    <= SQ_W'(mx7_q) * SQ_W'(mx7_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: partial products of the Heron product, right test
  // s0^2 + s1^2 - s2^2 = (a^2 + b^2 + c^2) - 2 * max^2
  // --------------------------------------------------------------------------
  logic [SUMSQ_W-1:0] twomx8;
  logic [SUMSQ_W-1:0] rdiff8;
  s2_t                s9_d;

  assign twomx8 = SUMSQ_W'({mxsq8_q, 1'b0});
  assign rdiff8 = (sumsq8_q >= twomx8) ? sumsq8_q - twomx8 : twomx8 - sumsq8_q;

  always_comb begin
    s9_d       = s8_q;
    s9_d.right = (rdiff8 <= SUMSQ_W'(tol_q));
  end

  s2_t               s9_q;
  logic [PROD_W-1:0] hh9_q, hl9_q, lh9_q, ll9_q;
  logic [MRAD_W-1:0] mrad9_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_q  <= s9_d;
      hh9_q <= PROD_W'(p12_8_q[PROD_W-1:FAC_W]) * PROD_W'(p34_8_q[PROD_W-1:FAC_W]);
      hl9_q <= PROD_W'(p12_8_q[PROD_W-1:FAC_W]) * PROD_W'(p34_8_q[FAC_W-1:0]);
      lh9_q <= PROD_W'(p12_8_q[FAC_W-1:0]) * PROD_W'(p34_8_q[PROD_W-1:FAC_W]);
      ll9_q <= PROD_W'(p12_8_q[FAC_W-1:0]) * PROD_W'(p34_8_q[FAC_W-1:0]);
      for (int k = 0; k < 3; k++) begin
        mrad9_q[k] <= mrad8_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 10: middle term
  // --------------------------------------------------------------------------
  s2_t                 s10_q;
  logic [PROD_W-1:0]   hh10_q, ll10_q;
  logic [PROD_W:0]     mid10_q;
  logic [MRAD_W-1:0]   mrad10_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_q   <= s9_q;
      hh10_q  <= hh9_q;
      ll10_q  <= ll9_q;
      mid10_q <= (PROD_W + 1)'(hl9_q) + (PROD_W + 1)'(lh9_q);
      for (int k = 0; k < 3; k++) begin
        mrad10_q[k] <= mrad9_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // area and median root: lane 0 is P / 2^(2F+4), lanes 1..3 median radicands
  // --------------------------------------------------------------------------
  localparam int unsigned FULL_W = 2 * PROD_W;

  logic [FULL_W-1:0]       heron10;
  logic [3:0][RAD2_W-1:0]  rad2;
  logic [3:0][ROOT2_W-1:0] root11;
  logic [S2_W-1:0]         side11;
  s2_t                     s11;

  assign heron10 = (FULL_W'(hh10_q) << (2 * FAC_W)) + (FULL_W'(mid10_q) << FAC_W) +
                   FULL_W'(ll10_q);

  always_comb begin
    rad2[0] = heron10[FULL_W-1:HERON_SH];
    for (int k = 0; k < 3; k++) begin
      rad2[k+1] = RAD2_W'(mrad10_q[k]);
    end
  end

  tmu_sqrt_pipe #(
    .LANES  (4),
    .RAD_W  (RAD2_W),
    .SIDE_W (S2_W)
  ) u_area_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v10_q),
    .rad_i   (rad2),
    .side_i  (s10_q),
    .valid_o (v11),
    .root_o  (root11),
    .side_o  (side11)
  );

  assign s11 = s2_t'(side11);

  // --------------------------------------------------------------------------
  // output register; a failed check zeroes the whole beat
  // --------------------------------------------------------------------------
  tmu_out_t           res_d, out_q;
  logic [ROOT2_W-2:0] med11 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      med11[k] = root11[k+1][ROOT2_W-1:1];
    end
    res_d              = '0;
    if (s11.tri_ok) begin
      res_d.valid_res  = 1'b1;
      res_d.side_a     = s11.a;
      res_d.side_b     = s11.b;
      res_d.side_c     = s11.c;
      res_d.perimeter  = s11.per;
      res_d.area       = (|root11[0][ROOT2_W-1:AREA_W]) ? '1 : root11[0][AREA_W-1:0];
      res_d.median_a   = (|med11[0][ROOT2_W-2:LEN_W]) ? '1 : med11[0][LEN_W-1:0];
      res_d.median_b   = (|med11[1][ROOT2_W-2:LEN_W]) ? '1 : med11[1][LEN_W-1:0];
      res_d.median_c   = (|med11[2][ROOT2_W-2:LEN_W]) ? '1 : med11[2][LEN_W-1:0];
      if (s11.right) begin
        res_d.is_right     = 1'b1;
        res_d.inradius     = s11.inr;
        res_d.circumradius = s11.circ;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res_d;
    end
  end

  assign out_data_o = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `TMU_ASSERT_IMP(a_fail_zero, out_valid_o && !out_data_o.valid_res, out_data_o == '0,
                  "failed triangle beat carries nonzero metrics")
  `TMU_ASSERT_IMP(a_radii_gated, out_valid_o && !out_data_o.is_right,
                  out_data_o.inradius == '0 && out_data_o.circumradius == '0,
                  "radii nonzero on a non-right triangle")
  `TMU_ASSERT_IMP(a_perimeter, out_valid_o && out_data_o.valid_res,
                  out_data_o.perimeter == PER_W'(out_data_o.side_a) +
                  PER_W'(out_data_o.side_b) + PER_W'(out_data_o.side_c),
                  "perimeter is not the sum of the sides")
  `TMU_ASSERT_NXT(a_freeze, !en, $stable(v3_q) && $stable(v10_q) && $stable(v11),
                  "pipeline moved while the output was stalled")

endmodule
